// ===== design/moa_pkg.sv =====
// moa_pkg: shared types and constants of the moments-about-origin unit
// no dependencies; imported by the front, queue, back and top level

package moa_pkg;

    // configuration register indexes
    localparam logic CFG_MAX_MOMENT   = 1'b0;
    localparam logic CFG_DENSITY_MODE = 1'b1;

    // widths of the configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // reset value of the max_moment configuration register
    localparam logic [2:0] MAX_MOMENT_RST = 3'd2;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // one interval job handed from front to back
    typedef struct packed {
        logic        close;    // an interval is closed by this sample
        logic        last;     // emit moments after this job
        logic        dens;     // density (trapezoid) weight
        logic        mid_neg;  // sign of the midpoint sum
        logic [31:0] mid_mag;  // magnitude of the midpoint, Q16.16
        logic        w_neg;    // sign of the density weight
        logic [32:0] ys_mag;   // magnitude of the y sum
        logic [32:0] dx_mag;   // magnitude of the x delta
        logic [31:0] prev_y;   // histogram weight
    } t_job;

endpackage

// ===== design/moa_smp_if.sv =====
// moa_smp_if: sample channel, one x/y sample per transaction
// depends on nothing

interface moa_smp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               last_sample;

    modport source (output valid, x_value, y_value, last_sample, input ready);
    modport sink   (input valid, x_value, y_value, last_sample, output ready);
endinterface

// ===== design/moa_mom_if.sv =====
// moa_mom_if: result channel, one moment per transaction
// depends on nothing

interface moa_mom_if;
    logic               valid;
    logic               ready;
    logic [2:0]         moment_order;
    logic signed [63:0] moment_sum;
    logic               final_result;

    modport source (output valid, moment_order, moment_sum, final_result, input ready);
    modport sink   (input valid, moment_order, moment_sum, final_result, output ready);
endinterface

// ===== design/moments_about_origin_unit.sv =====
// moments_about_origin_unit: top level, configuration registers and the three parts
// depends on moa_pkg, moa_smp_if, moa_mom_if, moa_front, moa_queue, moa_back
//
//  channel   | direction | transaction
//  ----------+-----------+-------------------------------------------------
//  i_smp     | in        | one sample: x_value, y_value, last_sample
//  o_mom     | out       | one moment: moment_order, moment_sum, final_result
//  i_cfg_*   | in        | register write: index 0 max_moment, 1 density_mode
//
// the front takes a sample whenever the two-entry job queue has room
// per interval the back steps S_ACC, S_MLO, S_MHI, S_CMB, S_SGN for each order up
// to MAX_MOMENT (S_WMUL and S_WSGN first in density mode): each order forms two
// 32x32 partial products; the last sample adds min(max_moment, MAX_MOMENT) + 1 moments of result output
// the result register holds while o_mom.ready is low; the back waits on it
// synchronous active-low reset clears the previous sample, queue and moments

module moments_about_origin_unit import moa_pkg::*; #(
    parameter int MAX_MOMENT = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    moa_smp_if.sink               i_smp,
    moa_mom_if.source             o_mom,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [2:0] r_max_moment;
    logic       r_density_mode;
    logic       w_push;
    logic       w_full;
    logic       w_qvalid;
    logic       w_pop;
    t_job       w_job_in;
    t_job       w_job_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_moment   <= MAX_MOMENT_RST;
            r_density_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_MOMENT:   r_max_moment   <= i_cfg_data[2:0];
                CFG_DENSITY_MODE: r_density_mode <= i_cfg_data[0];
                default:          r_max_moment   <= r_max_moment;
            endcase
        end
    end

    moa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_density_mode (r_density_mode),
        .i_smp          (i_smp),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_job          (w_job_in)
    );

    moa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_full  (w_full),
        .o_job   (w_job_out)
    );

    moa_back #(
        .MAX_MOMENT (MAX_MOMENT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_moment (r_max_moment),
        .i_job_valid  (w_qvalid),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .o_mom        (o_mom)
    );

endmodule

// ===== design/moa_front.sv =====
// moa_front: takes samples, keeps the previous one and forms interval jobs
// depends on moa_pkg and moa_smp_if

module moa_front import moa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_density_mode,
    moa_smp_if.sink i_smp,
    input  logic    i_full,
    output logic    o_push,
    output t_job    o_job
);

    logic               r_have_prev;
    logic signed [31:0] r_prev_x;
    logic signed [31:0] r_prev_y;

    logic               w_acc;
    logic signed [32:0] w_xsum;
    logic signed [32:0] w_ysum;
    logic signed [32:0] w_dx;
    logic [32:0]        w_xsum_mag;

    // handshake
    assign i_smp.ready = !i_full;
    assign w_acc       = i_smp.valid && !i_full;
    assign o_push      = w_acc && (r_have_prev || i_smp.last_sample);

    // interval arithmetic on the exact 33-bit sums
    assign w_xsum     = 33'(r_prev_x) + 33'(i_smp.x_value);
    assign w_ysum     = 33'(r_prev_y) + 33'(i_smp.y_value);
    assign w_dx       = 33'(i_smp.x_value) - 33'(r_prev_x);
    assign w_xsum_mag = w_xsum[32] ? 33'(-w_xsum) : 33'(w_xsum);

    // job fields
    always_comb begin
        o_job.close   = r_have_prev;
        o_job.last    = i_smp.last_sample;
        o_job.dens    = i_density_mode;
        o_job.mid_neg = w_xsum[32];
        o_job.mid_mag = w_xsum_mag[32:1];
        o_job.w_neg   = w_ysum[32] ^ w_dx[32];
        o_job.ys_mag  = w_ysum[32] ? 33'(-w_ysum) : 33'(w_ysum);
        o_job.dx_mag  = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
        o_job.prev_y  = r_prev_y;
    end

    // previous sample, cleared at the end of a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else if (w_acc) begin
            if (i_smp.last_sample) begin
                r_have_prev <= 1'b0;
                r_prev_x    <= '0;
                r_prev_y    <= '0;
            end else begin
                r_have_prev <= 1'b1;
                r_prev_x    <= i_smp.x_value;
                r_prev_y    <= i_smp.y_value;
            end
        end
    end

endmodule

// ===== design/moa_queue.sv =====
// moa_queue: short job queue between front and back
// depends on moa_pkg

module moa_queue import moa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_job o_job
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              w_pop;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_job   = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push && !o_full, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/moa_back.sv =====
// moa_back: weight, term chain and saturating accumulation; emits moments
// depends on moa_pkg and moa_mom_if

module moa_back import moa_pkg::*; #(
    parameter int MAX_MOMENT = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_max_moment,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    moa_mom_if.source  o_mom
);

    localparam int NACC = MAX_MOMENT + 1;
    localparam int IW   = $clog2(NACC);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_WMUL = 9'b000000010,
        S_WSGN = 9'b000000100,
        S_ACC  = 9'b000001000,
        S_MLO  = 9'b000010000,
        S_MHI  = 9'b000100000,
        S_CMB  = 9'b001000000,
        S_SGN  = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_idx;
    logic [63:0]         r_acc [NACC];
    logic [63:0]         r_term;
    logic [63:0]         r_amag;
    logic                r_neg;
    logic [65:0]         r_wprod;
    logic [63:0]         r_plo;
    logic [63:0]         r_phi;
    logic [63:0]         r_q;
    logic                r_ovld;
    logic [2:0]          r_order;
    logic [63:0]         r_sum;
    logic                r_final;

    logic [2:0]          w_top;
    logic                w_idx_last;
    logic                w_emit_last;
    logic                w_oload;
    logic [63:0]         w_acc_new;
    logic [48:0]         w_wmag;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (a[63] && b[63] && !s[63]) begin
            return 64'h8000_0000_0000_0000;
        end
        return s;
    endfunction

    // highest order reported
    assign w_top       = (5'(i_max_moment) > 5'(MAX_MOMENT)) ? 3'(MAX_MOMENT) : i_max_moment;
    assign w_idx_last  = r_idx == IW'(MAX_MOMENT);
    assign w_emit_last = 5'(r_idx) == 5'(w_top);
    assign w_oload     = (r_state == S_EMIT) && (!r_ovld || o_mom.ready);
    assign w_acc_new   = sat_add(r_acc[r_idx], r_term);
    assign w_wmag      = r_wprod[65:17];

    // job retires after its last accumulation or its last moment
    assign o_pop = ((r_state == S_ACC) && w_idx_last && !i_job.last)
                 || (w_oload && w_emit_last);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    if (!i_job.close) begin
                        n_state = S_EMIT;
                    end else if (i_job.dens) begin
                        n_state = S_WMUL;
                    end else begin
                        n_state = S_ACC;
                    end
                end
            end
            S_WMUL: n_state = S_WSGN;
            S_WSGN: n_state = S_ACC;
            S_ACC: begin
                if (!w_idx_last) begin
                    n_state = S_MLO;
                end else if (i_job.last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_CMB;
            S_CMB:  n_state = S_SGN;
            S_SGN:  n_state = S_ACC;
            S_EMIT: begin
                if (w_oload && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: r_idx <= '0;
                S_ACC: begin
                    if (w_idx_last) begin
                        r_idx <= '0;
                    end
                end
                S_SGN:  r_idx <= r_idx + 1'b1;
                S_EMIT: begin
                    if (w_oload) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    // datapath: weight, split 64x32 product, sign and saturation
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_term <= 64'(signed'(i_job.prev_y));
            S_WMUL: r_wprod <= i_job.ys_mag * i_job.dx_mag;
            S_WSGN: r_term <= i_job.w_neg ? -64'(w_wmag) : 64'(w_wmag);
            S_ACC: begin
                r_neg  <= r_term[63] ^ i_job.mid_neg;
                r_amag <= r_term[63] ? -r_term : r_term;
            end
            S_MLO:  r_plo <= r_amag[31:0] * i_job.mid_mag;
            S_MHI:  r_phi <= r_amag[63:32] * i_job.mid_mag;
            S_CMB: begin
                if (r_phi >= 64'h0000_8000_0000_0000) begin
                    r_q <= 64'h8000_0000_0000_0000;
                end else begin
                    r_q <= (r_phi << 16) + (r_plo >> 16);
                end
            end
            S_SGN: begin
                if (!r_neg) begin
                    r_term <= r_q[63] ? 64'h7FFF_FFFF_FFFF_FFFF : r_q;
                end else begin
                    r_term <= r_q[63] ? 64'h8000_0000_0000_0000 : -r_q;
                end
            end
            default: r_term <= r_term;
        endcase
    end

    // moment accumulators, cleared after the last moment leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NACC; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_state == S_ACC) begin
            r_acc[r_idx] <= w_acc_new;
        end else if (w_oload && w_emit_last) begin
            for (int i = 0; i < NACC; i++) begin
                r_acc[i] <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_oload) begin
            r_ovld <= 1'b1;
        end else if (o_mom.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_order <= 3'(r_idx);
            r_sum   <= r_acc[r_idx];
            r_final <= w_emit_last;
        end
    end

    assign o_mom.valid        = r_ovld;
    assign o_mom.moment_order = r_order;
    assign o_mom.moment_sum   = r_sum;
    assign o_mom.final_result = r_final;

endmodule

// ===== design/moa_checker.sv =====
// moa_checker: port-level checks of the moments-about-origin unit, bound to the top
// depends on the top level's ports only

module moa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_smp_ready,
    input logic        i_mom_valid,
    input logic        i_mom_ready,
    input logic [2:0]  i_mom_order,
    input logic [63:0] i_mom_sum,
    input logic        i_mom_final
);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mom_valid && !i_mom_ready |=> i_mom_valid && $stable(i_mom_sum)
            && $stable(i_mom_order) && $stable(i_mom_final))
        else $error("result changed while stalled");

    // nothing is shown right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_mom_valid)
        else $error("result valid after reset");

    // the empty queue takes samples right after reset
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_smp_ready)
        else $error("sample channel not ready after reset");

    // order seven is always the last of a run
    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mom_valid && i_mom_order == 3'd7 |-> i_mom_final)
        else $error("highest order not marked final");

endmodule

bind moments_about_origin_unit moa_checker u_moa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_smp_ready (i_smp.ready),
    .i_mom_valid (o_mom.valid),
    .i_mom_ready (o_mom.ready),
    .i_mom_order (o_mom.moment_order),
    .i_mom_sum   (o_mom.moment_sum),
    .i_mom_final (o_mom.final_result)
);
